// ===== rtl/core/pid_wheel_speed_controller_macros.svh =====
// Assertion macros for the wheel speed controller.
`ifndef PID_WHEEL_SPEED_CONTROLLER_MACROS_SVH
`define PID_WHEEL_SPEED_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PWSC_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define PWSC_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define PWSC_IMP(lbl, ck, rs, ante, cons, msg)
`define PWSC_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

// ===== rtl/core/pwsc_pkg.sv =====
// Shared types and constants of the wheel speed controller.
`timescale 1ns / 1ps
package pwsc_pkg;
  localparam int CMD_EPS_DEF   = 16;
  localparam int STILL_EPS_DEF = 16;
  localparam int ACC_W = 80;
  localparam int DIV_W = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_OUT_MIN    = 3'd3,
    REG_OUT_MAX    = 3'd4,
    REG_RAMP_STEP  = 3'd5,
    REG_KICK_START = 3'd6,
    REG_KICK_RUN   = 3'd7
  } cfg_reg_t;

  // 16-bit digit position of a partial product
  typedef enum logic [1:0] {
    POS_0 = 2'd0,
    POS_1 = 2'd1,
    POS_2 = 2'd2
  } mac_pos_t;

  typedef struct packed {
    logic     en;
    logic     clr;
    mac_pos_t pos;
  } mac_ctl_t;
endpackage

// ===== rtl/core/pwsc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pwsc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pwsc_pkg::DIV_W-1:0] dividend,
  input  logic [15:0]                divisor,
  output logic                       busy,
  output logic [pwsc_pkg::DIV_W-1:0] quotient
);
  localparam int CNT_W = $clog2(pwsc_pkg::DIV_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [15:0]      rem;
  logic [15:0]      dv;
  logic [16:0]      trial;
  logic             fits;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem, quotient[pwsc_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(pwsc_pkg::DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dv       <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= 16'(trial - {1'b0, dv});
      end else begin
        rem <= trial[15:0];
      end
      quotient <= {quotient[pwsc_pkg::DIV_W-2:0], fits};
    end
  end
endmodule

// ===== rtl/core/pwsc_mac.sv =====
// Shared 32x16 multiply-accumulate unit with digit-positioned products.
`timescale 1ns / 1ps
module pwsc_mac (
  input  logic                       clk,
  input  pwsc_pkg::mac_ctl_t         ctl,
  input  logic [31:0]                a,
  input  logic [15:0]                b,
  output logic [pwsc_pkg::ACC_W-1:0] acc
);
  logic [47:0]                prod;
  logic [pwsc_pkg::ACC_W-1:0] placed;

  assign prod = a * b;

  // place the partial product at its digit
  always_comb begin
    unique case (ctl.pos)
      pwsc_pkg::POS_0: placed = {32'b0, prod};
      pwsc_pkg::POS_1: placed = {16'b0, prod, 16'b0};
      pwsc_pkg::POS_2: placed = {prod, 32'b0};
      default:         placed = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) acc <= (ctl.clr ? '0 : acc) + placed;
  end
endmodule

// ===== rtl/core/pid_wheel_speed_controller.sv =====
// Top level of the wheel speed PID controller.
// Usage:
//   Input channel (in_valid / in_stall) takes one sample: target_speed,
//   measured_speed, elapsed_time and clear_state. in_stall is high while a
//   sample is in work; one sample is worked on at a time.
//   Output channel (out_valid / out_stall) gives drive_out and three flags,
//   held in an output register until the transfer completes, so the next
//   sample may be taken while a result waits.
//   Config channel (cfg_valid / cfg_ready) writes register cfg_index with
//   cfg_data; cfg_ready is always high. Write only while idle.
// Steps: elapsed_time of zero skips the division and the multiplies and gives
//   the last drive again. Otherwise the derivative division runs, then one
//   shared 32x16 multiplier is used one digit a cycle for error*dt and the P,
//   D and I terms; when anti-windup holds the integral, the I term runs again.
// Reset: registers go to their reset values, all state is zero, no result.
// A stalled receiver holds the result; a finished sample waits in its last
// step until the output register is free.
`timescale 1ns / 1ps
`include "pid_wheel_speed_controller_macros.svh"
module pid_wheel_speed_controller #(
  parameter int CMD_EPS   = pwsc_pkg::CMD_EPS_DEF,
  parameter int STILL_EPS = pwsc_pkg::STILL_EPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] target_speed,
  input  logic signed [15:0] measured_speed,
  input  logic [15:0]        elapsed_time,
  input  logic               clear_state,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] drive_out,
  output logic               integral_held,
  output logic               ramp_limited,
  output logic               kick_applied,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_PREP  = 12'b000000000010,
    S_DIV   = 12'b000000000100,
    S_EDT   = 12'b000000001000,
    S_NEWI  = 12'b000000010000,
    S_MUL   = 12'b000000100000,
    S_ADD   = 12'b000001000000,
    S_HELD  = 12'b000010000000,
    S_CLAMP = 12'b000100000000,
    S_RAMP  = 12'b001000000000,
    S_KICK  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  typedef enum logic [1:0] {
    T_P  = 2'd0,
    T_D  = 2'd1,
    T_IN = 2'd2,
    T_IO = 2'd3
  } term_t;

  localparam logic [79:0] TERM_LIM = 80'd1 << 61;
  localparam logic signed [49:0] INT_LIM = (50'sd1 <<< 47) - 50'sd1;

  state_t state;
  term_t  term;
  logic [1:0] dig;

  // configuration
  logic signed [31:0] gain_p, gain_i, gain_d;
  logic signed [15:0] out_min, out_max;
  logic [15:0] ramp_step;
  logic [14:0] kick_start_level, kick_run_level;

  // controller state
  logic signed [47:0] integral_sum;
  logic signed [15:0] previous_measurement, last_drive;

  // per-sample working registers
  logic signed [15:0] tgt, meas;
  logic [15:0]        dt;
  logic [15:0]        e_mag;
  logic               e_neg, diff_neg;
  logic signed [47:0] newi;
  logic [47:0]        newi_mag;
  logic signed [63:0] pd_sum, outq;
  logic signed [15:0] y;
  logic               held, ramped, kicked;

  // shared units
  pwsc_pkg::mac_ctl_t mac_ctl;
  logic [31:0]        mac_a;
  logic [15:0]        mac_b;
  logic [79:0]        acc;
  logic               div_start, div_busy;
  logic [31:0]        div_dvd, quotient;

  logic signed [16:0] diff, e_full;
  logic [15:0]        diff_mag;
  logic [47:0]        int_mag, opnd;
  logic [31:0]        gmag;
  logic               gneg, oneg;
  logic [1:0]         last_dig;
  logic [79:0]        mag80;
  logic [61:0]        sat;
  logic signed [63:0] tval;
  logic signed [49:0] ni;
  logic signed [63:0] hi_q, lo_q;
  logic signed [17:0] delta, rs;
  logic [16:0]        at, am, ay;
  logic [14:0]        lvl;
  logic               out_free;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
      out_min <= -16'sd32768;
      out_max <= 16'sd32767;
      ramp_step <= 16'hFFFF;
      kick_start_level <= '0;
      kick_run_level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pwsc_pkg::cfg_reg_t'(cfg_index))
        pwsc_pkg::REG_GAIN_P:     gain_p <= cfg_data;
        pwsc_pkg::REG_GAIN_I:     gain_i <= cfg_data;
        pwsc_pkg::REG_GAIN_D:     gain_d <= cfg_data;
        pwsc_pkg::REG_OUT_MIN:    out_min <= cfg_data[15:0];
        pwsc_pkg::REG_OUT_MAX:    out_max <= cfg_data[15:0];
        pwsc_pkg::REG_RAMP_STEP:  ramp_step <= cfg_data[15:0];
        pwsc_pkg::REG_KICK_START: kick_start_level <= cfg_data[14:0];
        pwsc_pkg::REG_KICK_RUN:   kick_run_level <= cfg_data[14:0];
      endcase
    end
  end

  // derivative numerator and error
  assign diff     = 17'(previous_measurement) - 17'(meas);
  assign diff_mag = diff[16] ? 16'(-diff) : diff[15:0];
  assign div_dvd  = {diff_mag, 16'b0};
  assign e_full   = 17'(tgt) - 17'(meas);
  assign int_mag  = integral_sum[47] ? 48'(-integral_sum) : 48'(integral_sum);

  // term operands
  always_comb begin
    unique case (term)
      T_P: begin
        gmag = gain_p[31] ? 32'(-gain_p) : 32'(gain_p);
        gneg = gain_p[31];
        opnd = {32'b0, e_mag};
        oneg = e_neg;
        last_dig = 2'd0;
      end
      T_D: begin
        gmag = gain_d[31] ? 32'(-gain_d) : 32'(gain_d);
        gneg = gain_d[31];
        opnd = {16'b0, quotient};
        oneg = diff_neg;
        last_dig = 2'd1;
      end
      T_IN: begin
        gmag = gain_i[31] ? 32'(-gain_i) : 32'(gain_i);
        gneg = gain_i[31];
        opnd = newi_mag;
        oneg = newi[47];
        last_dig = 2'd2;
      end
      T_IO: begin
        gmag = gain_i[31] ? 32'(-gain_i) : 32'(gain_i);
        gneg = gain_i[31];
        opnd = int_mag;
        oneg = integral_sum[47];
        last_dig = 2'd2;
      end
    endcase
  end

  // multiplier feed
  always_comb begin
    mac_ctl.en  = (state == S_EDT) || (state == S_MUL);
    mac_ctl.clr = (state == S_EDT) || (dig == 2'd0);
    mac_ctl.pos = pwsc_pkg::mac_pos_t'(dig);
    if (state == S_EDT) begin
      mac_a = {16'b0, e_mag};
      mac_b = dt;
    end else begin
      mac_a = gmag;
      unique case (dig)
        2'd0:    mac_b = opnd[15:0];
        2'd1:    mac_b = opnd[31:16];
        default: mac_b = opnd[47:32];
      endcase
    end
  end

  pwsc_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  assign div_start = (state == S_PREP) && (dt != 16'd0);

  pwsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (dt),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // term scaling, saturation and sign
  assign mag80 = (term == T_IN || term == T_IO) ? (acc >> 16) : acc;
  assign sat   = (mag80 > TERM_LIM) ? TERM_LIM[61:0] : mag80[61:0];
  assign tval  = (gneg ^ oneg) ? -$signed({2'b0, sat}) : $signed({2'b0, sat});

  // integral candidate
  always_comb begin
    ni = 50'(integral_sum) + (e_neg ? -$signed({17'b0, acc[32:0]})
                                    : $signed({17'b0, acc[32:0]}));
    if (ni > INT_LIM) ni = INT_LIM;
    if (ni < -INT_LIM) ni = -INT_LIM;
  end

  assign hi_q  = {{32{out_max[15]}}, out_max, 16'b0};
  assign lo_q  = {{32{out_min[15]}}, out_min, 16'b0};
  assign delta = 18'(y) - 18'(last_drive);
  assign rs    = {2'b0, ramp_step};
  assign at    = tgt[15] ? 17'(-17'(tgt)) : 17'(tgt);
  assign am    = meas[15] ? 17'(-17'(meas)) : 17'(meas);
  assign ay    = y[15] ? 17'(-17'(y)) : 17'(y);
  assign lvl   = (am < 17'(STILL_EPS)) ? kick_start_level : kick_run_level;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      integral_sum <= '0;
      previous_measurement <= '0;
      last_drive <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tgt  <= target_speed;
            meas <= measured_speed;
            dt   <= elapsed_time;
            if (clear_state) begin
              integral_sum <= '0;
              previous_measurement <= '0;
              last_drive <= '0;
            end
            state <= S_PREP;
          end
        end
        S_PREP: begin
          held <= 1'b0;
          ramped <= 1'b0;
          kicked <= 1'b0;
          e_mag <= e_full[16] ? 16'(-e_full) : e_full[15:0];
          e_neg <= e_full[16];
          diff_neg <= diff[16];
          dig <= 2'd0;
          term <= T_P;
          if (dt == 16'd0) begin
            y <= last_drive;
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!div_busy) state <= S_EDT;
        end
        S_EDT: state <= S_NEWI;
        S_NEWI: begin
          newi <= ni[47:0];
          newi_mag <= ni[49] ? 48'(-ni) : 48'(ni);
          state <= S_MUL;
        end
        S_MUL: begin
          if (dig == last_dig) state <= S_ADD;
          else dig <= dig + 2'd1;
        end
        S_ADD: begin
          dig <= 2'd0;
          unique case (term)
            T_P: begin
              pd_sum <= tval;
              term <= T_D;
              state <= S_MUL;
            end
            T_D: begin
              pd_sum <= pd_sum + tval;
              term <= T_IN;
              state <= S_MUL;
            end
            T_IN: begin
              outq <= pd_sum + tval;
              state <= S_HELD;
            end
            T_IO: begin
              outq <= pd_sum + tval;
              state <= S_CLAMP;
            end
          endcase
        end
        // conditional integration
        S_HELD: begin
          if ((outq > hi_q && !e_neg && e_mag != 16'd0) || (outq < lo_q && e_neg)) begin
            held <= 1'b1;
            term <= T_IO;
            state <= S_MUL;
          end else begin
            integral_sum <= newi;
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          priority if (outq > hi_q) y <= out_max;
          else if (outq < lo_q) y <= out_min;
          else y <= outq[31:16];
          state <= S_RAMP;
        end
        S_RAMP: begin
          priority if (delta > rs) begin
            y <= 16'(18'(last_drive) + rs);
            ramped <= 1'b1;
          end else if (delta < -rs) begin
            y <= 16'(18'(last_drive) - rs);
            ramped <= 1'b1;
          end
          state <= S_KICK;
        end
        // static-friction kick, then commit state
        S_KICK: begin
          previous_measurement <= meas;
          if (at > 17'(CMD_EPS) && ay < {2'b0, lvl}) begin
            y <= tgt[15] ? -$signed({1'b0, lvl}) : $signed({1'b0, lvl});
            last_drive <= tgt[15] ? -$signed({1'b0, lvl}) : $signed({1'b0, lvl});
            kicked <= 1'b1;
          end else begin
            last_drive <= y;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            drive_out <= y;
            integral_held <= held;
            ramp_limited <= ramped;
            kick_applied <= kicked;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PWSC_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall, "not busy after take")
  `PWSC_IMP(a_div_in_div, clk, rst, div_busy, state == S_DIV, "divider runs outside divide step")
  `PWSC_IMP(a_kick_nonzero, clk, rst, out_valid && kick_applied, drive_out != 16'sd0, "zero kick")
endmodule
